FILE: src/vct_pkg.sv
// shared types and constants for the value change tracker table
// no dependencies; every other source file uses this package

package vct_pkg;

  localparam int SLOT_W      = 3;
  localparam int SAMPLE_W    = 16;
  localparam int FRAME_W     = 32;
  localparam int VALUE_W     = 32;
  localparam int MODE_W      = 3;
  localparam int MASK_W      = 16;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int MODE_TBL_W  = 24;

  typedef enum logic [MODE_W-1:0] {
    MODE_CAPTURE     = 3'd0,
    MODE_PREV_VALUE  = 3'd1,
    MODE_CHG_FRAME   = 3'd2,
    MODE_CHG_COUNT   = 3'd3,
    MODE_PRIOR_FRAME = 3'd4
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MODE_TABLE = 2'd0,
    CFG_MASK_LOW   = 2'd1,
    CFG_MASK_HIGH  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [MODE_TBL_W-1:0] mode_table;
    logic [CFG_DATA_W-1:0] mask_high;
    logic [CFG_DATA_W-1:0] mask_low;
  } cfg_t;

endpackage

FILE: src/vct_if.sv
// valid/ready channel interfaces for input items and result items
// depends on vct_pkg for field widths

interface vct_item_if;
  logic                           valid;
  logic                           ready;
  logic [vct_pkg::SLOT_W-1:0]     slot;
  logic [vct_pkg::SAMPLE_W-1:0]   sample;
  logic [vct_pkg::FRAME_W-1:0]    frame;

  modport source (output valid, slot, sample, frame, input ready);
  modport sink (input valid, slot, sample, frame, output ready);
  modport monitor (input valid, ready, slot, sample, frame);
endinterface

interface vct_result_if;
  logic                           valid;
  logic                           ready;
  logic [vct_pkg::SLOT_W-1:0]     slot_out;
  logic [vct_pkg::VALUE_W-1:0]    value;

  modport source (output valid, slot_out, value, input ready);
  modport sink (input valid, slot_out, value, output ready);
  modport monitor (input valid, ready, slot_out, value);
endinterface

FILE: src/vct_cfg_regs.sv
// configuration registers: mode table and the two mask words
// depends on vct_pkg

module vct_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [vct_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [vct_pkg::CFG_DATA_W-1:0]   cfg_data,
  output vct_pkg::cfg_t                    cfg
);
  import vct_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE_TABLE: cfg.mode_table <= cfg_data[MODE_TBL_W-1:0];
        CFG_MASK_LOW:   cfg.mask_low   <= cfg_data;
        CFG_MASK_HIGH:  cfg.mask_high  <= cfg_data;
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

endmodule

FILE: src/vct_slot_table.sv
// per-slot tracking state and the mode logic that reads and updates it
// depends on vct_pkg

module vct_slot_table #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  vct_pkg::cfg_t                   cfg,
  input  logic                            fire,
  input  logic [vct_pkg::SLOT_W-1:0]      slot,
  input  logic [vct_pkg::SAMPLE_W-1:0]    sample,
  input  logic [vct_pkg::FRAME_W-1:0]     frame,
  output logic [vct_pkg::VALUE_W-1:0]     value
);
  import vct_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [SAMPLE_W-1:0] newest_distinct    [NUM_SLOTS];
  logic [SAMPLE_W-1:0] older_distinct     [NUM_SLOTS];
  logic [SAMPLE_W-1:0] last_seen          [NUM_SLOTS];
  logic [FRAME_W-1:0]  last_change_frame  [NUM_SLOTS];
  logic [FRAME_W-1:0]  prior_change_frame [NUM_SLOTS];
  logic [VALUE_W-1:0]  change_count       [NUM_SLOTS];

  logic                  present;
  logic [IDX_W-1:0]      idx;
  mode_t                 mode;
  logic [2*CFG_DATA_W-1:0] mask_all;
  logic [MASK_W-1:0]     mask_raw;
  logic [SAMPLE_W-1:0]   masked;
  logic                  seen_chg;
  logic                  newest_chg;
  logic [VALUE_W-1:0]    count_inc;

  always_comb begin
    present   = {1'b0, slot} < (SLOT_W+1)'(NUM_SLOTS);
    idx       = slot[IDX_W-1:0];
    mode      = mode_t'(cfg.mode_table[MODE_W*slot +: MODE_W]);
    mask_all  = {cfg.mask_high, cfg.mask_low};
    mask_raw  = mask_all[MASK_W*slot +: MASK_W];
    // an empty mask passes every bit
    masked    = sample & ((mask_raw == '0) ? {MASK_W{1'b1}} : mask_raw);
    seen_chg  = present && (masked != last_seen[idx]);
    newest_chg = present && (masked != newest_distinct[idx]);
    count_inc = present ? change_count[idx] + VALUE_W'(1) : '0;

    value = '0;
    if (present) begin
      case (mode)
        MODE_CAPTURE:     value = VALUE_W'(masked);
        MODE_PREV_VALUE:  value = VALUE_W'(newest_chg ? newest_distinct[idx]
                                                      : older_distinct[idx]);
        MODE_CHG_FRAME:   value = seen_chg ? frame : last_change_frame[idx];
        MODE_CHG_COUNT:   value = seen_chg ? count_inc : change_count[idx];
        MODE_PRIOR_FRAME: value = seen_chg ? last_change_frame[idx]
                                           : prior_change_frame[idx];
        default:          value = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        newest_distinct[i]    <= '0;
        older_distinct[i]     <= '0;
        last_seen[i]          <= '0;
        last_change_frame[i]  <= '0;
        prior_change_frame[i] <= '0;
        change_count[i]       <= '0;
      end
    end else if (fire && present) begin
      case (mode)
        MODE_PREV_VALUE: begin
          if (newest_chg) begin
            older_distinct[idx]  <= newest_distinct[idx];
            newest_distinct[idx] <= masked;
          end
        end
        MODE_CHG_FRAME: begin
          if (seen_chg) begin
            last_seen[idx]         <= masked;
            last_change_frame[idx] <= frame;
          end
        end
        MODE_CHG_COUNT: begin
          if (seen_chg) begin
            last_seen[idx]    <= masked;
            change_count[idx] <= count_inc;
          end
        end
        MODE_PRIOR_FRAME: begin
          if (seen_chg) begin
            last_seen[idx]          <= masked;
            prior_change_frame[idx] <= last_change_frame[idx];
            last_change_frame[idx]  <= frame;
          end
        end
        default: begin
          // capture and unknown modes leave the state alone
        end
      endcase
    end
  end

endmodule

FILE: src/value_change_tracker_table.sv
// top level of the value change tracker table: input register, slot table, result register
// depends on vct_pkg, vct_if, vct_cfg_regs and vct_slot_table
//
//  channel   dir  fields                        transfer when
//  items     in   slot, sample, frame           items.valid && items.ready
//  results   out  slot_out, value               results.valid && results.ready
//  cfg       in   cfg_we, cfg_index, cfg_data   cfg_we
//
// one item per cycle sustained while results.ready stays high; results.valid rises
// once the item has passed the input register and then the slot lookup and update
// into the result register
// the slot state is updated in the same cycle that the result register loads,
// so back-to-back items on the same slot see each other's effect
// rst is synchronous and clears the configuration and all slot state
// a stalled result holds; the input register still fills, then items.ready drops

module value_change_tracker_table #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  vct_item_if.sink                         items,
  vct_result_if.source                     results,
  input  logic                             cfg_we,
  input  logic [vct_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [vct_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vct_pkg::*;

  cfg_t                cfg;
  logic                s1_valid;
  logic [SLOT_W-1:0]   s1_slot;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [FRAME_W-1:0]  s1_frame;
  logic                advance;
  logic [VALUE_W-1:0]  value_next;
  logic                r_valid;
  logic [SLOT_W-1:0]   r_slot;
  logic [VALUE_W-1:0]  r_value;

  vct_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vct_slot_table #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_table (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (advance),
    .slot   (s1_slot),
    .sample (s1_sample),
    .frame  (s1_frame),
    .value  (value_next)
  );

  assign advance      = s1_valid && (!r_valid || results.ready);
  assign items.ready  = !s1_valid || advance;

  assign results.valid    = r_valid;
  assign results.slot_out = r_slot;
  assign results.value    = r_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      r_valid  <= 1'b0;
    end else begin
      if (items.ready) begin
        s1_valid <= items.valid;
      end
      if (advance) begin
        r_valid <= 1'b1;
      end else if (results.ready) begin
        r_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_slot   <= items.slot;
      s1_sample <= items.sample;
      s1_frame  <= items.frame;
    end
    if (advance) begin
      r_slot  <= s1_slot;
      r_value <= value_next;
    end
  end

endmodule

FILE: src/vct_checker.sv
// port-level checks for the value change tracker table, bound to the top level
// depends on vct_pkg

module vct_checker #(
  parameter int NUM_SLOTS = 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [vct_pkg::SLOT_W-1:0]    out_slot,
  input logic [vct_pkg::VALUE_W-1:0]   out_value
);
  import vct_pkg::*;

  // nothing comes out of reset pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(out_value) && $stable(out_slot))
    else $error("stalled result changed");

  // with the result register empty the input side is never blocked
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  // slots beyond the table report zero
  a_absent_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ({1'b0, out_slot} >= (SLOT_W+1)'(NUM_SLOTS))
      |-> out_value == '0)
    else $error("absent slot gave nonzero value");

  // an input transfer with a free result side passes the input register and then shows up
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing after input transfer");

endmodule

bind value_change_tracker_table vct_checker #(
  .NUM_SLOTS (NUM_SLOTS)
) u_vct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_slot  (results.slot_out),
  .out_value (results.value)
);

FILE: tb/vct_board_pkg.sv
// scoreboard for the value change tracker table: per-slot tracking state and result check
// depends on vct_pkg for widths, mode codes and register indexes

package vct_board_pkg;
  import vct_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } tracked_t;

  class tracked_value_board;
    int num_slots;
    int mismatches;

    logic [MODE_TBL_W-1:0] mode_word;
    logic [CFG_DATA_W-1:0] mask_low;
    logic [CFG_DATA_W-1:0] mask_high;

    logic [SAMPLE_W-1:0] newest [8];
    logic [SAMPLE_W-1:0] older [8];
    logic [SAMPLE_W-1:0] seen [8];
    logic [FRAME_W-1:0]  chg_frame [8];
    logic [FRAME_W-1:0]  prior_frame [8];
    logic [VALUE_W-1:0]  chg_count [8];

    tracked_t awaited_values [$];

    function new(int n);
      num_slots  = n;
      mismatches = 0;
      mode_word  = '0;
      mask_low   = '0;
      mask_high  = '0;
      foreach (newest[k]) begin
        newest[k]      = '0;
        older[k]       = '0;
        seen[k]        = '0;
        chg_frame[k]   = '0;
        prior_frame[k] = '0;
        chg_count[k]   = '0;
      end
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE_TABLE: mode_word = data[MODE_TBL_W-1:0];
        CFG_MASK_LOW:   mask_low  = data;
        CFG_MASK_HIGH:  mask_high = data;
        default: ;
      endcase
    endfunction

    // update the slot and return what the block reports for this sample
    function logic [VALUE_W-1:0] track_sample(logic [SLOT_W-1:0] s, logic [SAMPLE_W-1:0] raw,
                                              logic [FRAME_W-1:0] frame);
      logic [CFG_DATA_W-1:0] word;
      logic [MASK_W-1:0]     mask;
      logic [SAMPLE_W-1:0]   m;
      logic [MODE_W-1:0]     code;
      logic [VALUE_W-1:0]    value;
      bit                    changed;
      value = '0;
      if (s < num_slots) begin
        word = (s < 4) ? mask_low : mask_high;
        mask = word[16*s[1:0] +: 16];
        if (mask == '0) mask = '1;
        m       = raw & mask;
        code    = mode_word[3*s +: 3];
        changed = (m != seen[s]);
        case (code)
          MODE_CAPTURE: value = {16'd0, m};
          MODE_PREV_VALUE: begin
            if (m != newest[s]) begin
              older[s]  = newest[s];
              newest[s] = m;
            end
            value = {16'd0, older[s]};
          end
          MODE_CHG_FRAME: begin
            if (changed) begin
              seen[s]      = m;
              chg_frame[s] = frame;
            end
            value = chg_frame[s];
          end
          MODE_CHG_COUNT: begin
            if (changed) begin
              seen[s]      = m;
              chg_count[s] = chg_count[s] + 1;
            end
            value = chg_count[s];
          end
          MODE_PRIOR_FRAME: begin
            if (changed) begin
              seen[s]        = m;
              prior_frame[s] = chg_frame[s];
              chg_frame[s]   = frame;
            end
            value = prior_frame[s];
          end
          default: value = '0;
        endcase
      end
      return value;
    endfunction

    function void take_sample(logic [SLOT_W-1:0] s, logic [SAMPLE_W-1:0] raw,
                              logic [FRAME_W-1:0] frame);
      tracked_t want;
      want.slot  = s;
      want.value = track_sample(s, raw, frame);
      awaited_values.push_back(want);
    endfunction

    function void compare_result(logic [SLOT_W-1:0] slot_out, logic [VALUE_W-1:0] value);
      tracked_t want;
      if (awaited_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: slot %0d value %h", slot_out, value);
      end else begin
        want = awaited_values.pop_front();
        if (want.slot !== slot_out || want.value !== value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: slot exp %0d got %0d, value exp %h got %h",
                     want.slot, slot_out, want.value, value);
        end
      end
    endfunction

    function int pending();
      return awaited_values.size();
    endfunction

    function bit clean();
      return (mismatches == 0) && (awaited_values.size() == 0);
    endfunction
  endclass

endpackage

FILE: tb/tb_value_change_tracker_table.sv
// testbench top for the value change tracker table: directed and random samples over
// several register settings, random stalls on both channels; depends on vct_pkg, vct_if,
// vct_board_pkg and the block itself

module tb_value_change_tracker_table;
  timeunit 1ns;
  timeprecision 1ps;

  import vct_pkg::*;
  import vct_board_pkg::*;

  localparam int NUM_SLOTS      = 8;
  localparam int LONG_HOLD      = 150;
  localparam int SETTLE         = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [MODE_W-1:0] MODE_BAD_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_BAD_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_BAD_7 = 3'd7;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  vct_item_if   item_bus ();
  vct_result_if result_bus ();

  value_change_tracker_table #(.NUM_SLOTS(NUM_SLOTS)) uut (
    .clk       (clk),
    .rst       (rst),
    .items     (item_bus),
    .results   (result_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tracked_value_board board;

  bit                  no_idle   = 1'b0;
  bit                  want_hold = 1'b0;
  int                  quiet_cycles = 0;
  logic [FRAME_W-1:0]  frame_now;
  logic [SAMPLE_W-1:0] last_sent [8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // transfer monitor, scoreboard hookup and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (item_bus.valid && item_bus.ready)
        board.take_sample(item_bus.slot, item_bus.sample, item_bus.frame);
      if (result_bus.valid && result_bus.ready)
        board.compare_result(result_bus.slot_out, result_bus.value);
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    result_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (want_hold) begin
        result_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        want_hold = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_item(logic [SLOT_W-1:0] s, logic [SAMPLE_W-1:0] smp,
                           logic [FRAME_W-1:0] frm);
    if (!no_idle && !want_hold && $urandom_range(0, 5) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_bus.valid  <= 1'b1;
    item_bus.slot   <= s;
    item_bus.sample <= smp;
    item_bus.frame  <= frm;
    last_sent[s] = smp;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
  endtask

  // drop valid, wait for every result, then let the pipeline settle
  task automatic wait_quiet();
    item_bus.valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apply_config(logic [MODE_TBL_W-1:0] modes, logic [CFG_DATA_W-1:0] lo,
                              logic [CFG_DATA_W-1:0] hi);
    logic [CFG_DATA_W-1:0] mode_data;
    // junk above bit 23 must be ignored
    mode_data = {32'($urandom), 8'($urandom), modes};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE_TABLE;
    cfg_data  <= mode_data;
    @(posedge clk);
    cfg_index <= CFG_MASK_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_MASK_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(CFG_MODE_TABLE, mode_data);
    board.write_reg(CFG_MASK_LOW, lo);
    board.write_reg(CFG_MASK_HIGH, hi);
  endtask

  function automatic logic [MODE_TBL_W-1:0] rand_modes();
    logic [MODE_TBL_W-1:0] word;
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(0, 9) < 8)
        word[3*k +: 3] = 3'($urandom_range(MODE_CAPTURE, MODE_PRIOR_FRAME));
      else
        word[3*k +: 3] = 3'($urandom_range(MODE_BAD_5, MODE_BAD_7));
    end
    return word;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_masks();
    logic [CFG_DATA_W-1:0] word;
    int pick;
    for (int k = 0; k < 4; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3)
        word[16*k +: 16] = '0;
      else if (pick < 5)
        word[16*k +: 16] = '1;
      else if (pick < 7)
        word[16*k +: 16] = 16'h1 << $urandom_range(0, 15);
      else
        word[16*k +: 16] = 16'($urandom);
    end
    return word;
  endfunction

  // repeats and one-bit flips keep the change detectors busy both ways
  task automatic send_random(int count);
    logic [SLOT_W-1:0]   s;
    logic [SAMPLE_W-1:0] smp;
    int                  pick;
    repeat (count) begin
      s    = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 35)
        smp = last_sent[s];
      else if (pick < 50)
        smp = last_sent[s] ^ (16'h1 << $urandom_range(0, 15));
      else if (pick < 65)
        case ($urandom_range(0, 3))
          0: smp = 16'h0000;
          1: smp = 16'hffff;
          2: smp = 16'h8000;
          default: smp = 16'h0001;
        endcase
      else
        smp = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5)
        frame_now = $urandom;
      else if (pick < 8)
        frame_now = '1;
      else
        frame_now = frame_now + $urandom_range(0, 3);
      send_item(s, smp, frame_now);
    end
  endtask

  initial begin
    board = new(NUM_SLOTS);
    frame_now = '0;
    foreach (last_sent[k]) last_sent[k] = '0;
    rst             <= 1'b1;
    item_bus.valid  <= 1'b0;
    item_bus.slot   <= '0;
    item_bus.sample <= '0;
    item_bus.frame  <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_MODE_TABLE;
    cfg_data        <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: capture everywhere, masks all zero so every bit passes
    send_item(3'd0, 16'hffff, 32'hffff_ffff);
    send_item(3'd7, 16'h0000, 32'h0000_0000);

    // one mode per slot, unknown codes on slots 5 to 7
    wait_quiet();
    apply_config({MODE_BAD_7, MODE_BAD_6, MODE_BAD_5, MODE_PRIOR_FRAME, MODE_CHG_COUNT,
                  MODE_CHG_FRAME, MODE_PREV_VALUE, MODE_CAPTURE},
                 {16'h8001, 16'h00ff, 16'hffff, 16'h0000},
                 {16'h0000, 16'h1234, 16'hffff, 16'h0f0f});
    send_item(3'd0, 16'ha5a5, 32'd1);
    send_item(3'd1, 16'h1234, 32'd2);
    send_item(3'd1, 16'h1234, 32'd3);
    send_item(3'd1, 16'h5678, 32'd4);
    send_item(3'd2, 16'h12ab, 32'd10);
    send_item(3'd2, 16'hffab, 32'd11);  // same bits under the mask
    send_item(3'd2, 16'h0000, 32'd12);
    send_item(3'd3, 16'h8001, 32'd20);
    send_item(3'd3, 16'h7ffe, 32'd21);
    send_item(3'd3, 16'h7ffe, 32'd22);
    send_item(3'd4, 16'h0f0f, 32'd30);
    send_item(3'd4, 16'hf0f0, 32'd31);
    send_item(3'd4, 16'hffff, 32'hffff_ffff);
    send_item(3'd5, 16'hffff, 32'd40);
    send_item(3'd6, 16'h1234, 32'd41);
    send_item(3'd7, 16'hffff, 32'd42);

    // modes swapped at run time, slots keep what they hold
    wait_quiet();
    apply_config({MODE_CHG_COUNT, MODE_CHG_FRAME, MODE_PREV_VALUE, MODE_CAPTURE,
                  MODE_PREV_VALUE, MODE_CHG_FRAME, MODE_CHG_COUNT, MODE_PRIOR_FRAME},
                 '1, '0);
    send_item(3'd0, 16'h0001, 32'd50);
    send_item(3'd1, 16'h5678, 32'd51);
    send_item(3'd2, 16'h0000, 32'd52);
    send_item(3'd3, 16'h7ffe, 32'd53);
    send_item(3'd4, 16'h0f0f, 32'd54);
    send_item(3'd3, 16'h0000, 32'd55);

    // long result hold-off while items keep coming
    wait_quiet();
    apply_config(rand_modes(), '0, '0);
    want_hold = 1'b1;
    send_random(110);

    wait_quiet();
    apply_config({8{MODE_BAD_7}}, '1, '1);
    send_random(30);

    repeat (2) begin
      wait_quiet();
      apply_config(rand_modes(), rand_masks(), rand_masks());
      send_random(110);
    end

    // closing stretch at full rate
    wait_quiet();
    no_idle = 1'b1;
    apply_config(rand_modes(), rand_masks(), rand_masks());
    send_random(110);
    wait_quiet();

    if (board.clean())
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: value_change_tracker_table.f
src/vct_pkg.sv
src/vct_if.sv
src/vct_cfg_regs.sv
src/vct_slot_table.sv
src/value_change_tracker_table.sv
src/vct_checker.sv
tb/vct_board_pkg.sv
tb/tb_value_change_tracker_table.sv
